>>> src/fp16a_pkg.sv
// ----------------------------------------------------------------------------
// fp16a_pkg
// shared constants and types for the binary16 element-wise adder
// ----------------------------------------------------------------------------
package fp16a_pkg;

	localparam logic [15:0] EXP_MASK    = 16'h7C00;
	localparam logic [15:0] FRAC_MASK   = 16'h03FF;
	localparam logic [15:0] QUIET_BIT   = 16'h0200;
	localparam logic [15:0] DEFAULT_NAN = 16'h7E00;

	// special-case decision made in stage 1
	typedef enum logic [1:0] {
		SPC_NONE = 2'd0,
		SPC_PASS = 2'd1,
		SPC_ZERO = 2'd2
	} spc_t;

endpackage

>>> src/fp16_elementwise_adder.sv
// ----------------------------------------------------------------------------
// fp16_elementwise_adder
// element-wise binary16 sum with round to nearest even, four-stage pipeline
// ----------------------------------------------------------------------------
// usage:
//   input channel carries in_value, acc_value and last_in under in_valid /
//   in_stall; output channel carries sum_value and last_out under
//   out_valid / out_stall. an item moves when valid is high and stall is low.
//   every item gives exactly one result; last_out is last_in of that item.
//   an accepted item passes through the stage 1, 2, 3 and 4 registers in order;
//   out_valid is the valid bit of the stage 4 register.
//   throughput: one item per cycle while out_stall is low; every stage can advance
//   in every cycle while out_stall is low (align, add, normalise, round).
//   when the receiver stalls, the output register holds; in_stall rises only
//   when every stage holds an item and out_stall is high, so nothing is lost
//   or repeated. bubbles are squeezed out since an empty stage always moves.
//   reset clears all valid bits; payload registers are not reset.
//   nan, infinity, subnormal and signed zero follow ieee 754, no flags.
// ----------------------------------------------------------------------------
module fp16_elementwise_adder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] in_value,
	input  logic [15:0] acc_value,
	input  logic        last_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] sum_value,
	output logic        last_out
);

	// pipeline valid bits and per-stage advance
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4 = !(v_s4 && out_stall);
	assign adv3 = adv4 || !v_s3;
	assign adv2 = adv3 || !v_s2;
	assign adv1 = adv2 || !v_s1;
	assign in_stall = !adv1;

	// ---------------- stage 1: classify and align ----------------
	logic a_nan, b_nan, a_inf, b_inf;
	logic [4:0]  ea, eb;
	logic [10:0] ma, mb;
	logic [4:0]  ea_eff, eb_eff;
	logic        swap;
	logic [4:0]  d;
	logic [10:0] big_m, sml_m;
	logic [4:0]  big_e;
	logic [13:0] sml_sh;
	logic        sticky;
	logic [24:0] sml_full;
	logic        sign_big, sub_op;
	fp16a_pkg::spc_t spc_c;
	logic [15:0] pass_c;

	always_comb begin
		ea = in_value[14:10];
		eb = acc_value[14:10];
		a_nan = (ea == 5'h1F) && (in_value[9:0] != 10'd0);
		b_nan = (eb == 5'h1F) && (acc_value[9:0] != 10'd0);
		a_inf = (ea == 5'h1F) && (in_value[9:0] == 10'd0);
		b_inf = (eb == 5'h1F) && (acc_value[9:0] == 10'd0);
		ma = {(ea != 5'd0), in_value[9:0]};
		mb = {(eb != 5'd0), acc_value[9:0]};
		ea_eff = (ea == 5'd0) ? 5'd1 : ea;
		eb_eff = (eb == 5'd0) ? 5'd1 : eb;
		swap = {eb_eff, mb} > {ea_eff, ma};
		big_m = swap ? mb : ma;
		sml_m = swap ? ma : mb;
		big_e = swap ? eb_eff : ea_eff;
		d = swap ? (eb_eff - ea_eff) : (ea_eff - eb_eff);
		sign_big = swap ? acc_value[15] : in_value[15];
		sub_op = in_value[15] ^ acc_value[15];
		// shifted small operand with 3 extra bits below the mantissa; lower shifted-out bits fold into sticky
		sml_full = {sml_m, 14'd0} >> d;
		sml_sh = sml_full[24:11];
		sticky = (sml_full[10:0] != 11'd0);
		spc_c = fp16a_pkg::SPC_NONE;
		pass_c = 16'd0;
		if (a_nan) begin
			spc_c = fp16a_pkg::SPC_PASS;
			pass_c = in_value | fp16a_pkg::QUIET_BIT;
		end else if (b_nan) begin
			spc_c = fp16a_pkg::SPC_PASS;
			pass_c = acc_value | fp16a_pkg::QUIET_BIT;
		end else if (a_inf && b_inf) begin
			spc_c = fp16a_pkg::SPC_PASS;
			pass_c = sub_op ? fp16a_pkg::DEFAULT_NAN : in_value;
		end else if (a_inf) begin
			spc_c = fp16a_pkg::SPC_PASS;
			pass_c = in_value;
		end else if (b_inf) begin
			spc_c = fp16a_pkg::SPC_PASS;
			pass_c = acc_value;
		end else if (sub_op && (in_value[14:0] == acc_value[14:0])) begin
			spc_c = fp16a_pkg::SPC_ZERO;
			pass_c = 16'd0;
		end
	end

	logic [10:0] big_m_s1;
	logic [13:0] sml_s1;
	logic        sticky_s1, sub_s1, sign_s1, last_s1;
	logic [4:0]  exp_s1;
	fp16a_pkg::spc_t spc_s1;
	logic [15:0] pass_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			big_m_s1  <= big_m;
			sml_s1    <= sml_sh;
			sticky_s1 <= sticky;
			sub_s1    <= sub_op;
			sign_s1   <= sign_big;
			exp_s1    <= big_e;
			spc_s1    <= spc_c;
			pass_s1   <= pass_c;
			last_s1   <= last_in;
		end
	end

	// ---------------- stage 2: add or subtract ----------------
	// sum layout: [15] carry, [14:4] integer and fraction, [3:1] g r, [0] sticky
	logic [15:0] big_x, sml_x, sum_c;
	always_comb begin
		big_x = {1'b0, big_m_s1, 4'd0};
		sml_x = {1'b0, sml_s1, sticky_s1};
		sum_c = sub_s1 ? (big_x - sml_x) : (big_x + sml_x);
	end

	logic [15:0] sum_s2;
	logic [4:0]  exp_s2;
	logic        sign_s2, last_s2;
	fp16a_pkg::spc_t spc_s2;
	logic [15:0] pass_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			sum_s2  <= sum_c;
			exp_s2  <= exp_s1;
			sign_s2 <= sign_s1;
			spc_s2  <= spc_s1;
			pass_s2 <= pass_s1;
			last_s2 <= last_s1;
		end
	end

	// ---------------- stage 3: normalise ----------------
	logic [3:0]  lz;
	logic [4:0]  lsh;
	logic [15:0] norm_c;
	logic [5:0]  exp_n;
	always_comb begin
		lz = 4'd15;
		for (int i = 0; i < 15; i++) begin
			if (sum_s2[i]) lz = 4'(14 - i);
		end
		lsh = 5'd0;
		norm_c = sum_s2;
		exp_n = {1'b0, exp_s2};
		if (sum_s2[15]) begin
			// carry out: shift right one, keep sticky
			norm_c = {1'b0, sum_s2[15:2], sum_s2[1] | sum_s2[0]};
			exp_n = {1'b0, exp_s2} + 6'd1;
		end else begin
			// left shift limited so exponent does not drop below one
			lsh = ({1'b0, lz} < {1'b0, exp_s2}) ? {1'b0, lz} : (exp_s2 - 5'd1);
			norm_c = sum_s2 << lsh;
			exp_n = {1'b0, exp_s2} - {1'b0, lsh};
			// subnormal result carries biased exponent zero
			if (!norm_c[14]) exp_n = 6'd0;
		end
	end

	logic [15:0] norm_s3;
	logic [5:0]  exp_s3;
	logic        sign_s3, last_s3;
	fp16a_pkg::spc_t spc_s3;
	logic [15:0] pass_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			norm_s3 <= norm_c;
			exp_s3  <= exp_n;
			sign_s3 <= sign_s2;
			spc_s3  <= spc_s2;
			pass_s3 <= pass_s2;
			last_s3 <= last_s2;
		end
	end

	// ---------------- stage 4: round and pack ----------------
	logic        g, rs, up;
	logic [15:0] body;
	logic [15:0] res_c;
	always_comb begin
		g  = norm_s3[3];
		rs = norm_s3[2] | norm_s3[1] | norm_s3[0];
		up = g && (rs || norm_s3[4]);
		// exponent field and fraction concatenate so a mantissa carry bumps the exponent
		body = {1'b0, exp_s3[4:0], norm_s3[13:4]} + {15'd0, up};
		res_c = {sign_s3, body[14:0]};
		if (exp_s3[5] || (body[14:10] == 5'h1F)) res_c = {sign_s3, 15'h7C00};
		case (spc_s3)
			fp16a_pkg::SPC_PASS: res_c = pass_s3;
			fp16a_pkg::SPC_ZERO: res_c = 16'd0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			sum_value <= res_c;
			last_out  <= last_s3;
		end
	end

	assign out_valid = v_s4;

endmodule
